// File: sv/tssa_pkg.sv
// Shared constants for the transposed sparse matrix-vector scatter-accumulate block.
// Fixed field widths, store geometry, saturation bounds and operation codes.
// No dependencies.
package tssa_pkg;

	localparam int IDX_W         = 12;
	localparam int STORE_DEPTH   = 1 << IDX_W;
	localparam int VECTOR_LENGTH = 4096;
	localparam int OPND_W        = 16;
	localparam int PROD_W        = 2 * OPND_W;
	localparam int SUM_W         = 48;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic signed [SUM_W-1:0] sum_t;

endpackage

// File: sv/transposed_spmv_scatter_accumulate.sv
// Scatter-accumulate engine for out = A^T * x over a CSR matrix, one nonzero per beat.
// Holds the accumulator store as an internal synchronous memory with read forwarding.
// Depends on tssa_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall | op, col_index, vector_value, matrix_value
//  out     | source    | out_valid/out_stall | entry_index, entry_sum
//
// One beat is taken each cycle unless in_stall is high; a read is registered in stage 1,
// then in the output register. The rate is set by the single read-modify-write port pair
// of the accumulator memory, with the previous write forwarded when consecutive beats hit
// the same column. After reset a clearing pass zeroes all 4096 entries, one a cycle; in_stall
// stays high during it. A stalled output holds the pipeline only when a second read is ready.
module transposed_spmv_scatter_accumulate
	import tssa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [OPND_W-1:0] vector_value,
	input  logic signed [OPND_W-1:0] matrix_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [IDX_W-1:0]         entry_index,
	output logic signed [SUM_W-1:0]  entry_sum
);

	sum_t acc_mem [STORE_DEPTH];

	logic  clearing_q;
	idx_t  clr_cnt_q;

	logic                     s1_valid_s1;
	logic                     s1_op_s1;
	logic                     s1_live_s1;
	idx_t                     s1_idx_s1;
	logic signed [PROD_W-1:0] prod_s1;
	sum_t                     mem_rd_s1;

	logic wr_en_s2;
	idx_t wr_idx_s2;
	sum_t wr_data_s2;

	logic out_valid_q;
	idx_t out_idx_q;
	sum_t out_sum_q;

	logic                    advance;
	logic                    accept;
	logic                    s1_is_read;
	logic                    s1_write;
	sum_t                    base;
	logic signed [SUM_W:0]   sum_wide;
	sum_t                    sum_sat;
	sum_t                    read_val;
	logic                    mem_we;
	idx_t                    mem_wa;
	sum_t                    mem_wd;

	assign s1_is_read = s1_valid_s1 && (s1_op_s1 == OP_READ);
	// A read in flight may only leave when the output register can take it.
	assign advance    = !(s1_is_read && out_valid_q && out_stall);
	assign in_stall   = clearing_q || !advance;
	assign accept     = in_valid && !in_stall;
	assign s1_write   = s1_valid_s1 && (s1_op_s1 == OP_ACCUM) && s1_live_s1 && advance;

	// The beat ahead wrote after this beat's memory read was issued, so take its value.
	assign base = (wr_en_s2 && (wr_idx_s2 == s1_idx_s1)) ? wr_data_s2 : mem_rd_s1;

	assign sum_wide = {base[SUM_W-1], base} +
		{{(SUM_W+1-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	assign read_val = s1_live_s1 ? base : '0;

	assign mem_we = clearing_q || s1_write;
	assign mem_wa = clearing_q ? clr_cnt_q : s1_idx_s1;
	assign mem_wd = clearing_q ? '0 : sum_sat;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			acc_mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			mem_rd_s1 <= acc_mem[col_index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == IDX_W'(STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			wr_en_s2    <= 1'b0;
		end else if (advance) begin
			s1_valid_s1 <= accept;
			wr_en_s2    <= s1_write;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s1_op_s1   <= op;
			s1_idx_s1  <= col_index;
			s1_live_s1 <= (32'(col_index) < VECTOR_LENGTH);
			prod_s1    <= vector_value * matrix_value;
			wr_idx_s2  <= s1_idx_s1;
			wr_data_s2 <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && s1_is_read) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_is_read) begin
			out_idx_q <= s1_idx_s1;
			out_sum_q <= read_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_index = out_idx_q;
	assign entry_sum   = out_sum_q;

	// The clearing pass owns the write port, so nothing may be in flight during it.
	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (!s1_valid_s1 && !wr_en_s2))
		else $error("pipeline active during clearing pass");

	a_clear_covers_store: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> ($past(clr_cnt_q) == IDX_W'(STORE_DEPTH - 1)))
		else $error("clearing pass ended early");

	a_read_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && s1_is_read) |=> (out_valid && (entry_index == $past(s1_idx_s1))))
		else $error("read beat lost on its way to the output");

	a_stalled_read_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_is_read && !advance) |=> (s1_is_read && $stable(s1_idx_s1) && $stable(mem_rd_s1)))
		else $error("stalled read changed in flight");

endmodule
